FILE: src/xsr_pkg.sv
// xsr_pkg: shared constants and types for the xorshift128+ state recovery block.
// No dependencies.
package xsr_pkg;

    localparam int SHIFT_A = 23;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 26;
    localparam int NBITS   = 128;
    localparam int IDX_W   = $clog2(NBITS);
    localparam int WORD_W  = NBITS / 2;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] col;
    } gen_ctl_t;

endpackage

FILE: src/xsr_gen.sv
// xsr_gen: concrete xorshift128+ generator run from a unit state, one step per cycle while step is asserted.
// Gives the output LSB of the next step; column index selects the unit state bit.
// Depends on xsr_pkg.
module xsr_gen (
    input  logic              aclk,
    input  xsr_pkg::gen_ctl_t ctl,
    output logic              nbit
);

    logic [xsr_pkg::WORD_W-1:0] s0_reg;
    logic [xsr_pkg::WORD_W-1:0] s1_reg;
    logic [xsr_pkg::WORD_W-1:0] a_val;
    logic [xsr_pkg::WORD_W-1:0] b_val;
    logic [xsr_pkg::WORD_W-1:0] unit_val;

    always_comb begin
        a_val    = s0_reg ^ (s0_reg << xsr_pkg::SHIFT_A);
        b_val    = a_val ^ (a_val >> xsr_pkg::SHIFT_B) ^ s1_reg
                   ^ (s1_reg >> xsr_pkg::SHIFT_C);
        nbit     = s1_reg[0] ^ b_val[0];
        unit_val = {{(xsr_pkg::WORD_W-1){1'b0}}, 1'b1} << ctl.col[xsr_pkg::IDX_W-2:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            s0_reg <= ctl.col[xsr_pkg::IDX_W-1] ? '0 : unit_val;
            s1_reg <= ctl.col[xsr_pkg::IDX_W-1] ? unit_val : '0;
        end else if (ctl.step) begin
            s0_reg <= s1_reg;
            s1_reg <= b_val;
        end
    end

endmodule

FILE: src/xorshift128plus_state_recovery.sv
// Operation: builds the equation rows (one memory read-modify-write per row per state
// bit, plus drain), then per column searches for a pivot row, swaps it into place when
// it is not already there (ST_SWRD, ST_SWW1, ST_SWW2) and eliminates the column from
// every other row; one item at a time.
// Throughput: one item per solve; the row memory's single read port sets the pace.
// Reset: aresetn synchronous, active low; clears control and the output valid only.
// Depends on xsr_pkg and xsr_gen.
module xorshift128plus_state_recovery (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_observed_low,
    input  logic [63:0] s_observed_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_recovered_word0,
    output logic [63:0] m_recovered_word1,
    output logic        m_solve_failed
);

    localparam int N  = xsr_pkg::NBITS;
    localparam int IW = xsr_pkg::IDX_W;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001,
        ST_GEN  = 8'b00000010,
        ST_SRCH = 8'b00000100,
        ST_SWRD = 8'b00001000,
        ST_SWW1 = 8'b00010000,
        ST_SWW2 = 8'b00100000,
        ST_ELIM = 8'b01000000,
        ST_FIN  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [N-1:0] rows_mem [N];
    logic         rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [N-1:0] wr_data, rdata_reg;

    logic [2*IW:0] cnt_reg, cnt_next;
    logic [IW:0]   r_reg, r_next;
    logic [IW-1:0] i_reg, i_next, tag_reg, tag_next, p_reg, p_next, colq_reg, colq_next;
    logic          pend_reg, pend_next, bit_reg, bit_next, fail_reg, fail_next;
    logic [N-1:0]  prow_reg, prow_next, rhs_reg, rhs_next;
    logic          m_valid_reg, m_valid_next;
    logic [63:0]   w0_reg, w0_next, w1_reg, w1_next;
    logic          mf_reg, mf_next;

    xsr_pkg::gen_ctl_t gen_ctl;
    logic              gen_bit;

    xsr_gen u_gen (
        .aclk (aclk),
        .ctl  (gen_ctl),
        .nbit (gen_bit)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) rows_mem[wr_addr] <= wr_data;
        if (rd_en) rdata_reg <= rows_mem[rd_addr];
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_recovered_word0 = w0_reg;
    assign m_recovered_word1 = w1_reg;
    assign m_solve_failed    = mf_reg;

    always_comb begin
        logic [IW-1:0] row, col;
        logic          issue;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        r_next       = r_reg;
        i_next       = i_reg;
        tag_next     = tag_reg;
        p_next       = p_reg;
        colq_next    = colq_reg;
        pend_next    = pend_reg;
        bit_next     = bit_reg;
        fail_next    = fail_reg;
        prow_next    = prow_reg;
        rhs_next     = rhs_reg;
        m_valid_next = m_valid_reg;
        w0_next      = w0_reg;
        w1_next      = w1_reg;
        mf_next      = mf_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        gen_ctl      = '0;
        row          = cnt_reg[IW-1:0];
        col          = cnt_reg[2*IW-1:IW];
        issue        = 1'b0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                gen_ctl.col = '0;
                if (s_valid) begin
                    rhs_next     = {s_observed_high, s_observed_low};
                    fail_next    = 1'b0;
                    cnt_next     = '0;
                    pend_next    = 1'b0;
                    gen_ctl.load = 1'b1;
                    state_next   = ST_GEN;
                end
            end
            ST_GEN: begin
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = tag_reg;
                    wr_data = ((colq_reg == '0) ? '0 : rdata_reg)
                              | ({{(N-1){1'b0}}, bit_reg} << colq_reg);
                end
                issue     = !cnt_reg[2*IW];
                pend_next = issue;
                if (issue) begin
                    rd_en     = 1'b1;
                    rd_addr   = row;
                    tag_next  = row;
                    colq_next = col;
                    bit_next  = gen_bit;
                    cnt_next  = cnt_reg + 1'b1;
                    gen_ctl.col = col + 1'b1;
                    if (row == IW'(N-1)) gen_ctl.load = 1'b1;
                    else gen_ctl.step = 1'b1;
                end else if (!pend_reg) begin
                    i_next     = '0;
                    r_next     = '0;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                issue     = !r_reg[IW];
                pend_next = issue;
                if (issue) begin
                    rd_en    = 1'b1;
                    rd_addr  = r_reg[IW-1:0];
                    tag_next = r_reg[IW-1:0];
                    r_next   = r_reg + 1'b1;
                end
                if (pend_reg && rdata_reg[i_reg]) begin
                    p_next    = tag_reg;
                    prow_next = rdata_reg;
                    pend_next = 1'b0;
                    r_next    = '0;
                    state_next = (tag_reg == i_reg) ? ST_ELIM : ST_SWRD;
                end else if (!pend_reg && r_reg[IW]) begin
                    fail_next  = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_SWRD: begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = ST_SWW1;
            end
            ST_SWW1: begin
                wr_en      = 1'b1;
                wr_addr    = p_reg;
                wr_data    = rdata_reg;
                state_next = ST_SWW2;
            end
            ST_SWW2: begin
                wr_en            = 1'b1;
                wr_addr          = i_reg;
                wr_data          = prow_reg;
                rhs_next[i_reg]  = rhs_reg[p_reg];
                rhs_next[p_reg]  = rhs_reg[i_reg];
                state_next       = ST_ELIM;
            end
            ST_ELIM: begin
                issue     = !r_reg[IW];
                pend_next = issue;
                if (issue) begin
                    rd_en    = 1'b1;
                    rd_addr  = r_reg[IW-1:0];
                    tag_next = r_reg[IW-1:0];
                    r_next   = r_reg + 1'b1;
                end
                if (pend_reg && tag_reg != i_reg && rdata_reg[i_reg]) begin
                    wr_en   = 1'b1;
                    wr_addr = tag_reg;
                    wr_data = rdata_reg ^ prow_reg;
                    if (rhs_reg[i_reg]) rhs_next[tag_reg] = !rhs_reg[tag_reg];
                end
                if (!pend_reg && r_reg[IW]) begin
                    if (i_reg == IW'(N-1)) begin
                        state_next = ST_FIN;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        r_next     = {1'b0, i_reg + 1'b1};
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    w0_next      = fail_reg ? '0 : rhs_reg[63:0];
                    w1_next      = fail_reg ? '0 : rhs_reg[127:64];
                    mf_next      = fail_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
        cnt_reg  <= cnt_next;
        r_reg    <= r_next;
        i_reg    <= i_next;
        tag_reg  <= tag_next;
        p_reg    <= p_next;
        colq_reg <= colq_next;
        bit_reg  <= bit_next;
        fail_reg <= fail_next;
        prow_reg <= prow_next;
        rhs_reg  <= rhs_next;
        w0_reg   <= w0_next;
        w1_reg   <= w1_next;
        mf_reg   <= mf_next;
    end

endmodule
